// ===== rtl/core/lpse_pkg.sv =====
package lpse_pkg;

	localparam int unsigned POS_W   = 10;
	localparam int unsigned COUNT_W = 11;
	localparam int unsigned ORDER_W = 2;
	localparam int unsigned CFG_W   = 11;
	localparam int unsigned CMDQ_DEPTH = 2;

	// register indexes
	localparam logic REG_PIXEL_COUNT = 1'b0;
	localparam logic REG_CHAN_ORDER  = 1'b1;

	// colour orders
	localparam logic [ORDER_W-1:0] ORDER_RGB = 2'd0;
	localparam logic [ORDER_W-1:0] ORDER_GRB = 2'd1;

	// line symbols per data bit
	localparam logic [2:0] SYM_ONE  = 3'b110;
	localparam logic [2:0] SYM_ZERO = 3'b100;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [7:0] line_byte;
		logic       run_last;
		logic       frame_end;
		logic       config_error;
	} line_t;

	// classified pixel handed from front to back
	typedef struct packed {
		logic       err;
		logic       first;
		logic       last;
		logic [7:0] ch0;
		logic [7:0] ch1;
		logic [7:0] ch2;
	} cmd_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic head_valid;
	} cmdq_status_t;

	function automatic logic [23:0] expand_byte(input logic [7:0] v);
		logic [23:0] acc;
		acc = '0;
		for (int b = 7; b >= 0; b--) begin
			acc = {acc[20:0], (v[b] ? SYM_ONE : SYM_ZERO)};
		end
		return acc;
	endfunction

endpackage

// ===== rtl/core/lpse_front.sv =====
module lpse_front import lpse_pkg::*; #(
	parameter int unsigned MAX_PIXELS = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                pix_valid,
	output logic                pix_stall,
	input  pixel_t              pix,
	input  cmdq_status_t        q_status,
	output logic                push,
	output cmd_t                push_cmd
);

	localparam logic [16:0] MAX_PIX_V = 17'(MAX_PIXELS);

	logic [COUNT_W-1:0] pixel_count_q;
	logic [ORDER_W-1:0] chan_order_q;
	logic [POS_W-1:0]   pos_q;
	logic               cfg_bad;
	logic               last_pix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_count_q <= COUNT_W'(1);
			chan_order_q  <= ORDER_GRB;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PIXEL_COUNT: pixel_count_q <= cfg_data[COUNT_W-1:0];
				REG_CHAN_ORDER:  chan_order_q  <= cfg_data[ORDER_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg_bad = (pixel_count_q == '0)
		|| ({6'd0, pixel_count_q} > MAX_PIX_V)
		|| ((chan_order_q != ORDER_RGB) && (chan_order_q != ORDER_GRB));

	// a lowered count mid-frame also closes the frame
	assign last_pix = ({1'b0, pos_q} >= (pixel_count_q - COUNT_W'(1)));

	assign pix_stall = q_status.full;
	assign push      = pix_valid && !pix_stall;

	always_comb begin
		push_cmd.err   = cfg_bad;
		push_cmd.first = (pos_q == '0);
		push_cmd.last  = last_pix;
		push_cmd.ch0   = (chan_order_q == ORDER_RGB) ? pix.red : pix.green;
		push_cmd.ch1   = (chan_order_q == ORDER_RGB) ? pix.green : pix.red;
		push_cmd.ch2   = pix.blue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			if (cfg_bad || last_pix) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

endmodule

// ===== rtl/core/lpse_cmdq.sv =====
module lpse_cmdq import lpse_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  cmd_t         push_cmd,
	input  logic         pop,
	output cmdq_status_t q_status,
	output cmd_t         head_cmd
);

	localparam int unsigned PTR_W = $clog2(CMDQ_DEPTH);

	cmd_t                 mem_q [CMDQ_DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [PTR_W:0]       count_q;

	assign q_status.full       = (count_q == (PTR_W+1)'(CMDQ_DEPTH));
	assign q_status.head_valid = (count_q != '0);
	assign head_cmd            = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (PTR_W+1)'(1);
				2'b01:   count_q <= count_q - (PTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/lpse_back.sv =====
module lpse_back import lpse_pkg::*; #(
	parameter int unsigned GUARD_BYTES = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cmdq_status_t q_status,
	input  cmd_t         head_cmd,
	output logic         pop,
	output logic         line_valid,
	input  logic         line_stall,
	output line_t        line
);

	localparam int unsigned SPAN  = (GUARD_BYTES > 9) ? GUARD_BYTES : 9;
	localparam int unsigned CNT_W = $clog2(SPAN);
	localparam logic [CNT_W:0] GUARD_N = (CNT_W+1)'(GUARD_BYTES);
	localparam logic [CNT_W-1:0] SYM_END = CNT_W'(8);

	typedef enum logic [4:0] {
		PH_START = 5'b00001,
		PH_LEAD  = 5'b00010,
		PH_SYM   = 5'b00100,
		PH_TRAIL = 5'b01000,
		PH_ERR   = 5'b10000
	} phase_t;

	phase_t           phase_q;
	phase_t           cur_phase;
	phase_t           nxt_phase;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cur_cnt;
	logic [CNT_W-1:0] nxt_cnt;
	logic             adv;
	logic             emit;
	logic             done;
	logic             guard_end;
	logic [7:0]       sym_ch;
	logic [23:0]      sym_bits;
	logic [7:0]       sym_byte;
	line_t            nxt_line;
	line_t            line_q;
	logic             line_valid_q;

	assign adv  = !line_valid_q || !line_stall;
	assign emit = adv && q_status.head_valid;
	assign pop  = emit && done;

	// item start resolves to its first real phase without a spare cycle
	always_comb begin
		cur_cnt = cnt_q;
		if (phase_q == PH_START) begin
			cur_cnt = '0;
			if (head_cmd.err) begin
				cur_phase = PH_ERR;
			end else if (head_cmd.first && (GUARD_BYTES > 0)) begin
				cur_phase = PH_LEAD;
			end else begin
				cur_phase = PH_SYM;
			end
		end else begin
			cur_phase = phase_q;
		end
	end

	assign guard_end = (({1'b0, cur_cnt} + (CNT_W+1)'(1)) == GUARD_N);

	always_comb begin
		unique case (cur_cnt[3:0])
			4'd0, 4'd1, 4'd2: sym_ch = head_cmd.ch0;
			4'd3, 4'd4, 4'd5: sym_ch = head_cmd.ch1;
			default:          sym_ch = head_cmd.ch2;
		endcase
	end

	assign sym_bits = expand_byte(sym_ch);

	always_comb begin
		unique case (cur_cnt[3:0])
			4'd0, 4'd3, 4'd6: sym_byte = sym_bits[23:16];
			4'd1, 4'd4, 4'd7: sym_byte = sym_bits[15:8];
			default:          sym_byte = sym_bits[7:0];
		endcase
	end

	always_comb begin
		nxt_line  = '0;
		nxt_phase = cur_phase;
		nxt_cnt   = cur_cnt + CNT_W'(1);
		done      = 1'b0;
		unique case (cur_phase)
			PH_ERR: begin
				nxt_line.run_last     = 1'b1;
				nxt_line.config_error = 1'b1;
				done                  = 1'b1;
				nxt_phase             = PH_START;
			end
			PH_LEAD: begin
				if (guard_end) begin
					nxt_phase = PH_SYM;
					nxt_cnt   = '0;
				end
			end
			PH_SYM: begin
				nxt_line.line_byte = sym_byte;
				if (cur_cnt == SYM_END) begin
					nxt_line.run_last  = !head_cmd.last || (GUARD_BYTES == 0);
					nxt_line.frame_end = head_cmd.last && (GUARD_BYTES == 0);
					if (head_cmd.last && (GUARD_BYTES > 0)) begin
						nxt_phase = PH_TRAIL;
						nxt_cnt   = '0;
					end else begin
						done      = 1'b1;
						nxt_phase = PH_START;
					end
				end
			end
			PH_TRAIL: begin
				if (guard_end) begin
					nxt_line.run_last  = 1'b1;
					nxt_line.frame_end = 1'b1;
					done               = 1'b1;
					nxt_phase          = PH_START;
				end
			end
			default: begin
				nxt_phase = PH_START;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_START;
			cnt_q        <= '0;
			line_valid_q <= 1'b0;
		end else if (adv) begin
			line_valid_q <= q_status.head_valid;
			if (q_status.head_valid) begin
				phase_q <= nxt_phase;
				cnt_q   <= nxt_cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			line_q <= nxt_line;
		end
	end

	assign line_valid = line_valid_q;
	assign line       = line_q;

endmodule

// ===== rtl/core/led_pixel_spi_symbol_encoder_core.sv =====
// path: with the back end idle, the first line byte of a pixel passes through
//   the command queue and then the output register after its transfer
// throughput: one line byte per cycle out of the back-end sequencer while a
//   command is queued and line_stall is low; a pixel inside a frame gives 9
//   line bytes, 9 + GUARD_BYTES at frame start or end, 9 + 2 * GUARD_BYTES for
//   a one-pixel frame, and one error byte when the configuration is invalid
// reset: arst_n clears the queue, sequencer and frame position at once;
//   pixel_count comes up as 1 and the channel order as GRB
module led_pixel_spi_symbol_encoder_core import lpse_pkg::*; #(
	parameter int unsigned GUARD_BYTES = 8,
	parameter int unsigned MAX_PIXELS  = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	// configuration write port
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	// pixel channel
	input  logic             pix_valid,
	output logic             pix_stall,
	input  pixel_t           pix,
	// line byte channel
	output logic             line_valid,
	input  logic             line_stall,
	output line_t            line
);

	// front to queue
	logic         push;
	cmd_t         push_cmd;
	// queue to back
	cmdq_status_t q_status;
	cmd_t         head_cmd;
	logic         pop;

	// front: holds the registers and frame position, classifies each pixel
	// (error, first of frame, last of frame) and orders its channels
	lpse_front #(
		.MAX_PIXELS (MAX_PIXELS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.q_status  (q_status),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	// two-entry command queue lets the front take the next pixel while the
	// back is still sending the current one
	lpse_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.q_status (q_status),
		.head_cmd (head_cmd)
	);

	// back: guard bytes at frame start/end, nine symbol bytes or one error byte,
	// one per unstalled cycle, registered; pops the command on its last byte
	lpse_back #(
		.GUARD_BYTES (GUARD_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_status   (q_status),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.line_valid (line_valid),
		.line_stall (line_stall),
		.line       (line)
	);

endmodule

// ===== rtl/core/lpse_checker.sv =====
module lpse_checker import lpse_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  line_valid,
	input logic  line_stall,
	input line_t line
);

	// a stalled line byte holds until its transfer
	a_line_hold: assert property (@(posedge clk) disable iff (!arst_n)
		line_valid && line_stall |=> line_valid && $stable(line))
		else $error("line byte changed while stalled");

	// an error byte is a lone zero byte closing its pixel, never a frame end
	a_err_byte: assert property (@(posedge clk) disable iff (!arst_n)
		line_valid && line.config_error |->
			line.run_last && !line.frame_end && (line.line_byte == 8'd0))
		else $error("malformed error byte");

	// the frame end is always the last byte of its pixel
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		line_valid && line.frame_end |-> line.run_last && !line.config_error)
		else $error("frame end without run end");

endmodule

bind led_pixel_spi_symbol_encoder_core lpse_checker u_lpse_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.line_valid (line_valid),
	.line_stall (line_stall),
	.line       (line)
);
